// ===== design/range_add_point_query_tree_macros.svh =====
// Assertion macros used by the tree top-level design file.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef RANGE_ADD_POINT_QUERY_TREE_MACROS_SVH
`define RANGE_ADD_POINT_QUERY_TREE_MACROS_SVH
`ifndef SYNTHESIS
`define RAPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rapq check failed");
`define RAPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rapq check failed");
`else
`define RAPQ_ASSERT_NOW(lbl, ante, cons)
`define RAPQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/rapq_pkg.sv =====
// Shared constants, codes and structs for the lazy range-add tree.
// No dependencies.
package rapq_pkg;
  localparam int MAX_ELEMENTS = 1024;
  localparam int POS_W        = 10;
  localparam int IDX_W        = 11;
  localparam int SIZE_W       = 11;
  localparam int DATA_W       = 32;
  localparam int LEVELS       = 11;
  localparam int SLOTS        = 4;
  localparam int MEM_DEPTH    = 1024;
  localparam int ADDR_W       = 10;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_IDLE, ST_RUN, ST_RESP
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_RD, C_WR, C_FIN
  } cell_state_t;

  // one node to visit at a level, with the add pushed from its parent
  typedef struct packed {
    logic              valid;
    logic [IDX_W-1:0]  idx;
    logic [POS_W-1:0]  tl;
    logic [POS_W-1:0]  tr;
    logic              pflag;
    logic [DATA_W-1:0] psum;
  } entry_t;

  typedef struct packed {
    logic                  start;
    entry_t [SLOTS-1:0]    ents;
  } link_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [DATA_W-1:0] val;
  } op_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DATA_W-1:0] elem;
  } cell_stat_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } clr_t;
endpackage

// ===== design/rapq_if.sv =====
// Request channel interfaces: input requests and result requests.
// Depends on rapq_pkg for field widths.
interface rapq_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [rapq_pkg::POS_W-1:0]     pos_low;
  logic [rapq_pkg::POS_W-1:0]     pos_high;
  logic signed [rapq_pkg::DATA_W-1:0] value;
  modport source (output valid, kind, pos_low, pos_high, value, input ready);
  modport sink   (input valid, kind, pos_low, pos_high, value, output ready);
endinterface

interface rapq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rapq_pkg::DATA_W-1:0] element;
  logic                               status;
  modport source (output valid, element, status, input ready);
  modport sink   (input valid, element, status, output ready);
endinterface

// ===== design/rapq_level_cell.sv =====
// One tree level: node memory plus a visit sequencer; hands children down.
// Depends on rapq_pkg.
module rapq_level_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  rapq_pkg::op_t       op,
  input  rapq_pkg::clr_t      clr,
  input  rapq_pkg::link_t     in_link,
  output rapq_pkg::link_t     out_link,
  output rapq_pkg::cell_stat_t stat
);
  logic [rapq_pkg::DATA_W-1:0] sum_mem [rapq_pkg::MEM_DEPTH];
  logic                        flag_mem [rapq_pkg::MEM_DEPTH];

  rapq_pkg::cell_state_t st_r, st_nxt;
  rapq_pkg::entry_t [rapq_pkg::SLOTS-1:0] ent_r, ent_nxt, kid_r, kid_nxt;
  logic [1:0] slot_r, slot_nxt;
  logic [2:0] kcnt_r, kcnt_nxt;
  logic [rapq_pkg::DATA_W-1:0] elem_r, elem_nxt;
  logic [rapq_pkg::DATA_W-1:0] rd_sum_r;
  logic                        rd_flag_r;

  rapq_pkg::entry_t            cur;
  logic [rapq_pkg::DATA_W-1:0] s, w_sum;
  logic                        f, w_flag, we;
  logic                        is_leaf, covered, overlap, on_path, descend;
  logic [rapq_pkg::POS_W-1:0]  tm;
  logic [1:0]                  k0, k1;

  assign cur = ent_r[slot_r];

  always_ff @(posedge clk) begin
    rd_sum_r  <= sum_mem[cur.idx[rapq_pkg::ADDR_W-1:0]];
    rd_flag_r <= flag_mem[cur.idx[rapq_pkg::ADDR_W-1:0]];
    if (clr.en) begin
      sum_mem[clr.addr]  <= '0;
      flag_mem[clr.addr] <= 1'b0;
    end else if (we) begin
      sum_mem[cur.idx[rapq_pkg::ADDR_W-1:0]]  <= w_sum;
      flag_mem[cur.idx[rapq_pkg::ADDR_W-1:0]] <= w_flag;
    end
  end

  always_comb begin
    s       = rd_sum_r + (cur.pflag ? cur.psum : '0);
    f       = rd_flag_r | cur.pflag;
    is_leaf = (cur.tl == cur.tr);
    tm      = cur.tl + ((cur.tr - cur.tl) >> 1);
    covered = (op.lo <= cur.tl) && (cur.tr <= op.hi);
    overlap = (op.lo <= cur.tr) && (cur.tl <= op.hi);
    on_path = (cur.tl <= op.lo) && (op.lo <= cur.tr);
    k0      = kcnt_r[1:0];
    k1      = kcnt_r[1:0] + 2'd1;

    st_nxt   = st_r;
    ent_nxt  = ent_r;
    kid_nxt  = kid_r;
    slot_nxt = slot_r;
    kcnt_nxt = kcnt_r;
    elem_nxt = elem_r;
    we       = 1'b0;
    w_sum    = s;
    w_flag   = f;
    descend  = 1'b0;
    out_link = '0;
    stat.done = 1'b0;
    stat.busy = (st_r != rapq_pkg::C_IDLE);
    stat.elem = elem_r;

    case (st_r)
      rapq_pkg::C_IDLE: begin
        if (in_link.start) begin
          ent_nxt  = in_link.ents;
          kid_nxt  = '0;
          slot_nxt = 2'd0;
          kcnt_nxt = 3'd0;
          elem_nxt = '0;
          st_nxt   = rapq_pkg::C_RD;
        end
      end
      rapq_pkg::C_RD: begin
        if (cur.valid) begin
          st_nxt = rapq_pkg::C_WR;
        end else if (slot_r == 2'd3) begin
          st_nxt = rapq_pkg::C_FIN;
        end else begin
          slot_nxt = slot_r + 2'd1;
        end
      end
      rapq_pkg::C_WR: begin
        we = 1'b1;
        if (op.kind == rapq_pkg::KIND_ADD) begin
          if (covered) begin
            w_sum  = s + op.val;
            w_flag = 1'b1;
          end else if (overlap) begin
            descend = 1'b1;
          end
        end else if (on_path) begin
          if (!is_leaf) begin
            descend = 1'b1;
          end else if (op.kind == rapq_pkg::KIND_LOAD) begin
            w_sum = op.val;
          end else begin
            elem_nxt = s;
          end
        end
        if (descend) begin
          // lazy push: a flagged node hands its sum to both children
          if (f) begin
            w_sum = '0;
          end
          w_flag = 1'b0;
          kid_nxt[k0] = '{valid: 1'b1, idx: {cur.idx[rapq_pkg::IDX_W-2:0], 1'b0},
                          tl: cur.tl, tr: tm, pflag: f, psum: s};
          kid_nxt[k1] = '{valid: 1'b1, idx: {cur.idx[rapq_pkg::IDX_W-2:0], 1'b1},
                          tl: tm + 10'd1, tr: cur.tr, pflag: f, psum: s};
          kcnt_nxt = kcnt_r + 3'd2;
        end
        if (slot_r == 2'd3) begin
          st_nxt = rapq_pkg::C_FIN;
        end else begin
          slot_nxt = slot_r + 2'd1;
          st_nxt   = rapq_pkg::C_RD;
        end
      end
      rapq_pkg::C_FIN: begin
        if (kcnt_r != 3'd0) begin
          out_link.start = 1'b1;
          out_link.ents  = kid_r;
        end else begin
          stat.done = 1'b1;
        end
        st_nxt = rapq_pkg::C_IDLE;
      end
      default: st_nxt = rapq_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= rapq_pkg::C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    ent_r  <= ent_nxt;
    kid_r  <= kid_nxt;
    slot_r <= slot_nxt;
    kcnt_r <= kcnt_nxt;
    elem_r <= elem_nxt;
  end
endmodule

// ===== design/range_add_point_query_tree.sv =====
// Range-add / point-query array kept as a lazy segment tree, one cell per level.
// Depends on rapq_pkg, rapq_if.sv, rapq_level_cell and the macros header.
// After reset the node memories are cleared, and no request is taken until
// the clear is done. A request walks down the chain of eleven level cells
// from the root, one cell at a time. A cell scans four slots: each node it
// visits takes a read state (a registered memory read) and then a write
// state, each empty slot takes a read state alone, and the scan ends in a
// hand-off state. The tree depth is 10 at 1024 elements. A range add visits
// up to four nodes per level below the root's children. Out-of-range loads
// and queries, empty ranges and the unused kind answer without touching the
// tree. The next request is taken the cycle after the result moves into the
// output register, even while that register still waits on the receiver.
`include "range_add_point_query_tree_macros.svh"
module range_add_point_query_tree (
  input  logic                        clk,
  input  logic                        rst_n,
  rapq_in_if.sink                     in_chan,
  rapq_out_if.source                  out_chan,
  input  logic                        cfg_we,
  input  logic [rapq_pkg::SIZE_W-1:0] cfg_wdata
);
  rapq_pkg::top_state_t st_r, st_nxt;
  logic [rapq_pkg::SIZE_W-1:0] size_r;
  logic [rapq_pkg::SIZE_W-1:0] clr_cnt_r, clr_cnt_nxt;
  rapq_pkg::op_t op_r, op_nxt;
  logic [rapq_pkg::DATA_W-1:0] res_elem_r, res_elem_nxt;
  logic res_stat_r, res_stat_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [rapq_pkg::DATA_W-1:0] out_elem_r, out_elem_nxt;
  logic out_stat_r, out_stat_nxt;

  rapq_pkg::link_t      links [rapq_pkg::LEVELS+1];
  rapq_pkg::cell_stat_t stats [rapq_pkg::LEVELS];
  rapq_pkg::clr_t       clr;
  rapq_pkg::link_t      root_link;

  logic [rapq_pkg::SIZE_W-1:0] n_eff;
  logic [rapq_pkg::POS_W-1:0]  n_m1, hi_c;
  logic                        accept, any_done, any_busy;
  logic [rapq_pkg::DATA_W-1:0] done_elem;

  // effective size: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (size_r == '0) begin
      n_eff = rapq_pkg::SIZE_W'(1);
    end else if (size_r > rapq_pkg::SIZE_W'(rapq_pkg::MAX_ELEMENTS)) begin
      n_eff = rapq_pkg::SIZE_W'(rapq_pkg::MAX_ELEMENTS);
    end else begin
      n_eff = size_r;
    end
    n_m1 = rapq_pkg::POS_W'(n_eff - rapq_pkg::SIZE_W'(1));
    hi_c = (in_chan.pos_high > n_m1) ? n_m1 : in_chan.pos_high;
  end

  always_comb begin
    any_done  = 1'b0;
    any_busy  = 1'b0;
    done_elem = '0;
    for (int i = 0; i < rapq_pkg::LEVELS; i++) begin
      any_done  = any_done | stats[i].done;
      any_busy  = any_busy | stats[i].busy;
      done_elem = done_elem | stats[i].elem & {rapq_pkg::DATA_W{stats[i].done}};
    end
  end

  assign in_chan.ready   = (st_r == rapq_pkg::ST_IDLE);
  assign accept          = in_chan.valid && in_chan.ready;
  assign out_chan.valid  = out_valid_r;
  assign out_chan.element = out_elem_r;
  assign out_chan.status = out_stat_r;
  assign links[0]        = root_link;

  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    res_elem_nxt  = res_elem_r;
    res_stat_nxt  = res_stat_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_elem_nxt  = out_elem_r;
    out_stat_nxt  = out_stat_r;
    clr.en        = 1'b0;
    clr.addr      = clr_cnt_r[rapq_pkg::ADDR_W-1:0];
    root_link     = '0;

    case (st_r)
      rapq_pkg::ST_CLEAR: begin
        clr.en      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + rapq_pkg::SIZE_W'(1);
        if (clr_cnt_r == rapq_pkg::SIZE_W'(rapq_pkg::MEM_DEPTH - 1)) begin
          st_nxt = rapq_pkg::ST_IDLE;
        end
      end
      rapq_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt       = '{kind: in_chan.kind, lo: in_chan.pos_low, hi: hi_c,
                           val: in_chan.value};
          res_elem_nxt = '0;
          res_stat_nxt = 1'b0;
          st_nxt       = rapq_pkg::ST_RESP;
          if (in_chan.kind == rapq_pkg::KIND_LOAD || in_chan.kind == rapq_pkg::KIND_QUERY) begin
            if ({1'b0, in_chan.pos_low} >= n_eff) begin
              res_stat_nxt = 1'b1;
            end else begin
              st_nxt = rapq_pkg::ST_RUN;
            end
          end else if (in_chan.kind == rapq_pkg::KIND_ADD) begin
            if (in_chan.pos_low <= hi_c) begin
              st_nxt = rapq_pkg::ST_RUN;
            end
          end
          if (st_nxt == rapq_pkg::ST_RUN) begin
            // root node covers the whole array, nothing pushed into it
            root_link.start        = 1'b1;
            root_link.ents[0]      = '0;
            root_link.ents[0].valid = 1'b1;
            root_link.ents[0].idx  = rapq_pkg::IDX_W'(1);
            root_link.ents[0].tl   = '0;
            root_link.ents[0].tr   = n_m1;
          end
        end
      end
      rapq_pkg::ST_RUN: begin
        if (any_done) begin
          if (op_r.kind == rapq_pkg::KIND_QUERY) begin
            res_elem_nxt = done_elem;
          end
          st_nxt = rapq_pkg::ST_RESP;
        end
      end
      rapq_pkg::ST_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = res_elem_r;
          out_stat_nxt  = res_stat_r;
          st_nxt        = rapq_pkg::ST_IDLE;
        end
      end
      default: st_nxt = rapq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= rapq_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      size_r      <= rapq_pkg::SIZE_W'(rapq_pkg::MAX_ELEMENTS);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
    end
    op_r       <= op_nxt;
    res_elem_r <= res_elem_nxt;
    res_stat_r <= res_stat_nxt;
    out_elem_r <= out_elem_nxt;
    out_stat_r <= out_stat_nxt;
  end

  // chain of level cells, root at level 0
  for (genvar g = 0; g < rapq_pkg::LEVELS; g++) begin : g_level
    rapq_level_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op       (op_r),
      .clr      (clr),
      .in_link  (links[g]),
      .out_link (links[g+1]),
      .stat     (stats[g])
    );
  end

  `RAPQ_ASSERT_NOW(a_ready_idle_cells, in_chan.ready, !any_busy)
  `RAPQ_ASSERT_NEXT(a_done_to_resp, st_r == rapq_pkg::ST_RUN && any_done, st_r == rapq_pkg::ST_RESP)
  `RAPQ_ASSERT_NOW(a_no_walk_past_leaf, 1'b1, !links[rapq_pkg::LEVELS].start)
  `RAPQ_ASSERT_NEXT(a_result_held, out_valid_r && !out_chan.ready, out_valid_r && $stable(out_elem_r))
endmodule
